[src/ptfe_pkg.sv]
package ptfe_pkg;

   // Wide datapath: holds the Horner sums of evaluate and the dividend of a fit
   localparam int WIDE_W = 232;
   localparam int COEF_W = 64;
   localparam int FIELD_W = 32;

   // Action codes carried on the request side
   localparam logic [1:0] ACT_EVAL = 2'd0;
   localparam logic [1:0] ACT_CUBIC = 2'd1;
   localparam logic [1:0] ACT_QUINTIC = 2'd2;

   // Status codes
   localparam logic ST_OK = 1'b0;
   localparam logic ST_BAD_INTERVAL = 1'b1;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_ADD,
      OP_MUL,
      OP_DIV
   } unit_op_type;

   typedef struct packed {
      unit_op_type op;
      logic [WIDE_W-1:0] operand;
      logic [FIELD_W-1:0] mplier;
   } unit_cmd_type;

   typedef struct packed {
      logic busy;
      logic ovf;
      logic [WIDE_W-1:0] acc;
      logic [COEF_W-1:0] quo;
   } unit_stat_type;

endpackage

[src/polynomial_trajectory_fit_eval.sv]
// Trajectory segment engine. A request either fits a cubic (action 1) or a
// quintic (action 2) segment from an interval and boundary conditions, storing
// six Q32.32 coefficients, or evaluates (action 0) position, velocity,
// acceleration and jerk at a sample time. Each request yields one response;
// a fit answers zeros in tdata, status 1 when the interval is zero; action 3
// answers zeros. All work runs through one shared wide unit that multiplies
// one bit of a 32-bit operand per cycle and divides one quotient bit per
// cycle while it is busy. An evaluate takes 14 multiplies. The request side
// is not ready while a request is in work.
module polynomial_trajectory_fit_eval
   import ptfe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // sample_time, interval, start_pos, start_vel, start_acc, end_pos,
   // end_vel, end_acc (lowest bit up)
   input  logic [255:0] req_tdata,
   // action
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // position, velocity, acceleration, jerk_value (lowest bit up)
   output logic [127:0] rsp_tdata,
   // status, saturated (lowest bit up)
   output logic [1:0]   rsp_tuser
);

   typedef enum logic [4:0] {
      S_IDLE, S_WAIT,
      S_F_LDA, S_F_M1, S_F_ADV, S_F_M2, S_F_ADP, S_F_NUM, S_F_MD, S_F_DEN,
      S_F_DIV, S_F_STORE, S_F_COMMIT,
      S_E_LD, S_E_MUL, S_E_ADD, S_E_FIN, S_E_RND,
      S_OUT
   } state_type;

   typedef struct packed {
      logic signed [39:0] fa;
      logic signed [39:0] fv;
      logic signed [39:0] fp;
   } fit_terms_type;

   state_type state_ff, ret_ff;
   logic               quintic_ff;
   logic               eval_ff;
   logic [FIELD_W-1:0] s_ff, t_ff;
   logic [FIELD_W-1:0] p1_ff, v1_ff, a1_ff, p2_ff, v2_ff, a2_ff;
   logic [COEF_W-1:0]  coef_ff [6];
   logic [COEF_W-1:0]  new_ff [6];
   logic [WIDE_W-1:0]  num_ff, den_ff, mag_ff;
   logic               neg_ff;
   logic [2:0]         k_ff, pw_ff, r_ff, j_ff;
   logic               sat_ff, status_ff;
   logic [FIELD_W-1:0] res_ff [4];
   logic               rsp_valid_ff;
   logic [127:0]       rsp_data_ff;
   logic [1:0]         rsp_user_ff;

   unit_cmd_type  cmd;
   unit_stat_type stat;

   ptfe_wide_unit u_unit (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   function automatic logic [WIDE_W-1:0] sext40(input logic [39:0] x);
      sext40 = {{(WIDE_W-40){x[39]}}, x};
   endfunction

   function automatic logic [39:0] s40(input logic [FIELD_W-1:0] x);
      s40 = {{8{x[FIELD_W-1]}}, x};
   endfunction

   // Derivative factor k!/(k-r)!
   function automatic logic [5:0] dfac(input logic [2:0] k, input logic [2:0] r);
      logic [5:0] f;
      f = 6'd1;
      for (int i = 0; i < 3; i++) begin
         if (3'(i) < r) begin
            f = 6'(f * 6'(k - 3'(i)));
         end
      end
      dfac = f;
   endfunction

   // Closed-form numerator terms of one fit coefficient
   fit_terms_type ft;
   logic signed [39:0] p1x, v1x, a1x, p2x, v2x, a2x, dpx;
   always_comb begin
      p1x = s40(p1_ff);
      v1x = s40(v1_ff);
      a1x = s40(a1_ff);
      p2x = s40(p2_ff);
      v2x = s40(v2_ff);
      a2x = s40(a2_ff);
      dpx = p2x - p1x;
      ft = '0;
      if (!quintic_ff) begin
         if (k_ff == 3'd2) begin
            ft.fv = -(40'sd2 * v1x + v2x);
            ft.fp = 40'sd3 * dpx;
         end else begin
            ft.fv = v1x + v2x;
            ft.fp = -(40'sd2 * dpx);
         end
      end else begin
         unique case (k_ff)
            3'd3: begin
               ft.fa = a2x - 40'sd3 * a1x;
               ft.fv = -(40'sd8 * v2x + 40'sd12 * v1x);
               ft.fp = 40'sd20 * dpx;
            end
            3'd4: begin
               ft.fa = 40'sd3 * a1x - 40'sd2 * a2x;
               ft.fv = 40'sd14 * v2x + 40'sd16 * v1x;
               ft.fp = -(40'sd30 * dpx);
            end
            default: begin
               ft.fa = a2x - a1x;
               ft.fv = -(40'sd6 * (v1x + v2x));
               ft.fp = 40'sd12 * dpx;
            end
         endcase
      end
   end

   // Evaluate term: derivative factor times the chosen coefficient
   logic [2:0]          ev_k;
   logic signed [70:0]  g_val;
   logic [WIDE_W-1:0]   g_ext;
   logic [7:0]          g_sh;
   always_comb begin
      ev_k = (state_ff == S_E_LD) ? 3'd5 : 3'(r_ff + j_ff - 3'd1);
      g_val = $signed(coef_ff[ev_k]) * $signed({1'b0, dfac(ev_k, r_ff)});
      g_ext = {{(WIDE_W-71){g_val[70]}}, g_val};
      g_sh = (state_ff == S_E_LD) ? 8'd0 : {1'b0, 3'(3'd6 - r_ff - j_ff), 4'd0};
   end

   // Drive the shared unit from the sequencer state
   logic [7:0] num_sh;
   assign num_sh = 8'({k_ff, 4'd0}) - 8'd15;
   always_comb begin
      cmd.op = OP_NONE;
      cmd.operand = '0;
      cmd.mplier = t_ff;
      unique case (state_ff)
         S_F_LDA: begin
            cmd.op = OP_LOAD;
            cmd.operand = sext40(ft.fa);
         end
         S_F_M1, S_F_M2, S_F_MD: cmd.op = OP_MUL;
         S_F_ADV: begin
            cmd.op = OP_ADD;
            cmd.operand = sext40(ft.fv) << 16;
         end
         S_F_ADP: begin
            cmd.op = OP_ADD;
            cmd.operand = sext40(ft.fp) << 32;
         end
         S_F_NUM: begin
            cmd.op = OP_LOAD;
            cmd.operand = quintic_ff ? WIDE_W'(2) : WIDE_W'(1);
         end
         S_F_DEN: begin
            cmd.op = OP_ADD;
            cmd.operand = num_ff << num_sh;
         end
         S_F_DIV: begin
            cmd.op = OP_DIV;
            cmd.operand = den_ff << 1;
         end
         S_E_LD: begin
            cmd.op = OP_LOAD;
            cmd.operand = g_ext;
         end
         S_E_MUL: begin
            cmd.op = OP_MUL;
            cmd.mplier = s_ff;
         end
         S_E_ADD: begin
            cmd.op = OP_ADD;
            cmd.operand = g_ext << g_sh;
         end
         default: cmd.op = OP_NONE;
      endcase
   end

   // Round the quotient into a saturated Q32.32 coefficient
   logic [COEF_W-1:0] coef_res;
   logic              coef_sat;
   always_comb begin
      coef_sat = 1'b0;
      coef_res = neg_ff ? (64'd0 - stat.quo) : stat.quo;
      if (stat.ovf || (!neg_ff && stat.quo[63])
          || (neg_ff && stat.quo > 64'h8000_0000_0000_0000)) begin
         coef_sat = 1'b1;
         coef_res = neg_ff ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end
   end

   // Scale and take magnitude of one derivative sum
   logic [WIDE_W-1:0] fin_t;
   assign fin_t = stat.acc << {r_ff, 4'd0};

   // Round to Q16.16 and clamp
   logic [WIDE_W-1:0]  rnd;
   logic [FIELD_W-1:0] ev_v, ev_lim, ev_out;
   logic               ev_sat;
   always_comb begin
      rnd = mag_ff + (WIDE_W'(1) << 95);
      ev_v = (|rnd[WIDE_W-1:128]) ? '1 : rnd[127:96];
      ev_lim = neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
      ev_sat = ev_v > ev_lim;
      if (ev_sat) begin
         ev_v = ev_lim;
      end
      ev_out = neg_ff ? (32'd0 - ev_v) : ev_v;
   end

   // Sequencer, coefficient store and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            coef_ff[i] <= '0;
         end
      end else begin
         // Drop the response after its transfer unless a new one is loaded
         if (rsp_valid_ff && rsp_tready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  s_ff <= req_tdata[31:0];
                  t_ff <= req_tdata[63:32];
                  p1_ff <= req_tdata[95:64];
                  v1_ff <= req_tdata[127:96];
                  a1_ff <= req_tdata[159:128];
                  p2_ff <= req_tdata[191:160];
                  v2_ff <= req_tdata[223:192];
                  a2_ff <= req_tdata[255:224];
                  quintic_ff <= req_tuser == ACT_QUINTIC;
                  eval_ff <= req_tuser == ACT_EVAL;
                  k_ff <= (req_tuser == ACT_QUINTIC) ? 3'd3 : 3'd2;
                  r_ff <= 3'd0;
                  sat_ff <= 1'b0;
                  status_ff <= ST_OK;
                  for (int i = 0; i < 4; i++) begin
                     res_ff[i] <= '0;
                  end
                  priority if (req_tuser == ACT_EVAL) begin
                     state_ff <= S_E_LD;
                  end else if ((req_tuser == ACT_CUBIC || req_tuser == ACT_QUINTIC)
                               && req_tdata[63:32] == '0) begin
                     status_ff <= ST_BAD_INTERVAL;
                     state_ff <= S_OUT;
                  end else if (req_tuser == ACT_CUBIC || req_tuser == ACT_QUINTIC) begin
                     state_ff <= S_F_LDA;
                  end else begin
                     state_ff <= S_OUT;
                  end
               end
            end
            S_WAIT: begin
               if (!stat.busy) begin
                  state_ff <= ret_ff;
               end
            end
            S_F_LDA: state_ff <= S_F_M1;
            S_F_M1: begin
               ret_ff <= S_F_ADV;
               state_ff <= S_WAIT;
            end
            S_F_ADV: state_ff <= S_F_M2;
            S_F_M2: begin
               ret_ff <= S_F_ADP;
               state_ff <= S_WAIT;
            end
            S_F_ADP: state_ff <= S_F_NUM;
            S_F_NUM: begin
               neg_ff <= stat.acc[WIDE_W-1];
               num_ff <= stat.acc[WIDE_W-1] ? (WIDE_W'(0) - stat.acc) : stat.acc;
               pw_ff <= k_ff;
               state_ff <= S_F_MD;
            end
            S_F_MD: begin
               pw_ff <= pw_ff - 3'd1;
               ret_ff <= (pw_ff == 3'd1) ? S_F_DEN : S_F_MD;
               state_ff <= S_WAIT;
            end
            S_F_DEN: begin
               den_ff <= stat.acc;
               state_ff <= S_F_DIV;
            end
            S_F_DIV: begin
               ret_ff <= S_F_STORE;
               state_ff <= S_WAIT;
            end
            S_F_STORE: begin
               new_ff[k_ff] <= coef_res;
               sat_ff <= sat_ff | coef_sat;
               if ((quintic_ff && k_ff == 3'd5) || (!quintic_ff && k_ff == 3'd3)) begin
                  state_ff <= S_F_COMMIT;
               end else begin
                  k_ff <= k_ff + 3'd1;
                  state_ff <= S_F_LDA;
               end
            end
            S_F_COMMIT: begin
               coef_ff[0] <= {{16{p1_ff[31]}}, p1_ff, 16'd0};
               coef_ff[1] <= {{16{v1_ff[31]}}, v1_ff, 16'd0};
               coef_ff[2] <= quintic_ff ? {{17{a1_ff[31]}}, a1_ff, 15'd0} : new_ff[2];
               coef_ff[3] <= new_ff[3];
               coef_ff[4] <= quintic_ff ? new_ff[4] : '0;
               coef_ff[5] <= quintic_ff ? new_ff[5] : '0;
               state_ff <= S_OUT;
            end
            S_E_LD: begin
               j_ff <= 3'(3'd5 - r_ff);
               state_ff <= S_E_MUL;
            end
            S_E_MUL: begin
               ret_ff <= S_E_ADD;
               state_ff <= S_WAIT;
            end
            S_E_ADD: begin
               j_ff <= j_ff - 3'd1;
               state_ff <= (j_ff == 3'd1) ? S_E_FIN : S_E_MUL;
            end
            S_E_FIN: begin
               neg_ff <= fin_t[WIDE_W-1];
               mag_ff <= fin_t[WIDE_W-1] ? (WIDE_W'(0) - fin_t) : fin_t;
               state_ff <= S_E_RND;
            end
            S_E_RND: begin
               res_ff[r_ff[1:0]] <= ev_out;
               sat_ff <= sat_ff | ev_sat;
               if (r_ff == 3'd3) begin
                  state_ff <= S_OUT;
               end else begin
                  r_ff <= r_ff + 3'd1;
                  state_ff <= S_E_LD;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff <= eval_ff ? {res_ff[3], res_ff[2], res_ff[1], res_ff[0]}
                                         : '0;
                  rsp_user_ff <= {sat_ff, status_ff};
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule

[src/ptfe_wide_unit.sv]
module ptfe_wide_unit
   import ptfe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  unit_cmd_type  cmd,
   output unit_stat_type stat
);

   logic [WIDE_W-1:0]  acc_ff;
   logic [WIDE_W-1:0]  mcand_ff;
   logic [WIDE_W-1:0]  div_ff;
   logic [FIELD_W-1:0] mplier_ff;
   logic [COEF_W-1:0]  quo_ff;
   logic [5:0]         cnt_ff;
   logic               busy_ff;
   logic               divmode_ff;
   logic               ovf_ff;

   logic [WIDE_W-1:0] add_a;
   logic [WIDE_W-1:0] add_b;
   logic              add_ci;
   logic [WIDE_W:0]   sum;

   // Select the operands of the one shared adder
   always_comb begin
      add_a = '0;
      add_b = '0;
      add_ci = 1'b0;
      priority if (busy_ff && !divmode_ff) begin
         add_a = acc_ff << 1;
         add_b = mplier_ff[FIELD_W-1] ? mcand_ff : '0;
      end else if (busy_ff) begin
         add_a = {acc_ff[WIDE_W-2:0], quo_ff[COEF_W-1]};
         add_b = ~div_ff;
         add_ci = 1'b1;
      end else if (cmd.op == OP_ADD) begin
         add_a = acc_ff;
         add_b = cmd.operand;
      end else if (cmd.op == OP_DIV) begin
         add_a = acc_ff >> COEF_W;
         add_b = ~cmd.operand;
         add_ci = 1'b1;
      end else begin
         add_a = '0;
      end
   end

   assign sum = {1'b0, add_a} + {1'b0, add_b} + {{WIDE_W{1'b0}}, add_ci};

   // Run one multiply bit or one quotient bit per cycle, else take a command
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         divmode_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_ff <= 1'b0;
         end
         if (!divmode_ff) begin
            acc_ff <= sum[WIDE_W-1:0];
            mplier_ff <= mplier_ff << 1;
         end else begin
            acc_ff <= sum[WIDE_W] ? sum[WIDE_W-1:0] : add_a;
            quo_ff <= {quo_ff[COEF_W-2:0], sum[WIDE_W]};
         end
      end else begin
         unique case (cmd.op)
            OP_LOAD: acc_ff <= cmd.operand;
            OP_ADD: acc_ff <= sum[WIDE_W-1:0];
            OP_MUL: begin
               mcand_ff <= acc_ff;
               acc_ff <= '0;
               mplier_ff <= cmd.mplier;
               cnt_ff <= 6'd31;
               busy_ff <= 1'b1;
               divmode_ff <= 1'b0;
            end
            OP_DIV: begin
               div_ff <= cmd.operand;
               acc_ff <= acc_ff >> COEF_W;
               quo_ff <= acc_ff[COEF_W-1:0];
               ovf_ff <= sum[WIDE_W];
               cnt_ff <= 6'd63;
               busy_ff <= 1'b1;
               divmode_ff <= 1'b1;
            end
            OP_NONE: ;
            default: ;
         endcase
      end
   end

   assign stat.busy = busy_ff;
   assign stat.ovf = ovf_ff;
   assign stat.acc = acc_ff;
   assign stat.quo = quo_ff;

endmodule

[src/ptfe_checker.sv]
module ptfe_checker
   import ptfe_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [1:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   // A stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // The engine works on one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request side ready right after a transfer");

   // A rejected fit carries zero data and no clamp flag
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] == ST_BAD_INTERVAL |-> rsp_tdata == '0 && !rsp_tuser[1])
      else $error("rejected fit with nonzero payload");

   // A quintic fit keeps the request side not ready right after its accept
   a_fit_slow: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == ACT_QUINTIC |=> !req_tready)
      else $error("fit finished too early");

endmodule

bind polynomial_trajectory_fit_eval ptfe_checker u_ptfe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[dv/tb.sv]
module tb;
   import ptfe_pkg::*;

   typedef struct {
      logic [1:0]  action;
      logic [31:0] sample_time;
      logic [31:0] interval;
      logic [31:0] start_pos;
      logic [31:0] start_vel;
      logic [31:0] start_acc;
      logic [31:0] end_pos;
      logic [31:0] end_vel;
      logic [31:0] end_acc;
   } segment_req_type;

   typedef struct {
      logic [31:0] position;
      logic [31:0] velocity;
      logic [31:0] acceleration;
      logic [31:0] jerk_value;
      logic        status;
      logic        saturated;
   } motion_rsp_type;

   localparam logic [1:0] ACT_UNUSED = 2'd3;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [255:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;
   logic [1:0]   rsp_tuser;

   segment_req_type pending_reqs[$];
   motion_rsp_type  expected_motion[$];
   segment_req_type in_flight;
   logic signed [63:0] segment_coef[6];

   int  sender_idle_pct;
   int  receiver_stall_pct;
   int  mismatch_count;
   int  hold_left;
   bit  hold_request;

   polynomial_trajectory_fit_eval dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 10-unit clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Solve one closed-form coefficient N / (d * T^k) in Q32.32; bit 64 flags a clamp
   function automatic logic [64:0] solve_coef(logic signed [63:0] fa, logic signed [63:0] fv,
                                              logic signed [63:0] fp, logic [31:0] t,
                                              int k, int d);
      logic signed [255:0] num;
      logic signed [255:0] wa;
      logic signed [255:0] wv;
      logic signed [255:0] wp;
      logic [255:0] tw;
      logic [255:0] mag;
      logic [255:0] den;
      logic [255:0] quo;
      logic neg;
      tw = {224'd0, t};
      wa = fa;
      wv = fv;
      wp = fp;
      num = wa * tw * tw + ((wv * tw) << 16) + (wp << 32);
      neg = num[255];
      mag = neg ? -num : num;
      mag = mag << (16 * k - 16);
      den = d;
      for (int i = 0; i < k; i++) den = den * tw;
      quo = ((mag << 1) + den) / (den << 1);
      if (|quo[255:64]) return neg ? {1'b1, 64'h8000000000000000} : {1'b1, 64'h7FFFFFFFFFFFFFFF};
      if (!neg && quo[63]) return {1'b1, 64'h7FFFFFFFFFFFFFFF};
      if (neg && quo[63:0] > 64'h8000000000000000) return {1'b1, 64'h8000000000000000};
      return {1'b0, neg ? -quo[63:0] : quo[63:0]};
   endfunction

   // Derivative of order r at time s, rounded to Q16.16; bit 32 flags a clamp
   function automatic logic [32:0] sample_derivative(int r, logic [31:0] s);
      logic signed [255:0] sum;
      logic signed [255:0] term;
      logic [255:0] mag;
      logic [255:0] top;
      logic [31:0] v;
      logic [31:0] lim;
      logic neg;
      logic clamped;
      int f;
      sum = '0;
      for (int k = r; k < 6; k++) begin
         f = 1;
         for (int j = 0; j < r; j++) f = f * (k - j);
         term = segment_coef[k];
         term = term * f;
         for (int j = 0; j < k - r; j++) term = term * {224'd0, s};
         sum = sum + (term << (16 * (5 - (k - r))));
      end
      neg = sum[255];
      mag = neg ? -sum : sum;
      mag = mag + (256'd1 << 95);
      top = mag >> 96;
      v = (|top[255:32]) ? 32'hFFFFFFFF : top[31:0];
      lim = neg ? 32'h80000000 : 32'h7FFFFFFF;
      clamped = v > lim;
      if (clamped) v = lim;
      return {clamped, neg ? -v : v};
   endfunction

   // Advance the segment state for one accepted request and return its response
   function automatic motion_rsp_type run_segment(segment_req_type rq);
      motion_rsp_type rs;
      logic signed [63:0] p1, v1, a1, p2, v2, a2;
      logic signed [63:0] c[6];
      logic [64:0] cr;
      logic [32:0] dr;
      rs = '{default: '0};
      p1 = $signed(rq.start_pos);
      v1 = $signed(rq.start_vel);
      a1 = $signed(rq.start_acc);
      p2 = $signed(rq.end_pos);
      v2 = $signed(rq.end_vel);
      a2 = $signed(rq.end_acc);
      if (rq.action == ACT_EVAL) begin
         dr = sample_derivative(0, rq.sample_time);
         rs.position = dr[31:0];
         rs.saturated |= dr[32];
         dr = sample_derivative(1, rq.sample_time);
         rs.velocity = dr[31:0];
         rs.saturated |= dr[32];
         dr = sample_derivative(2, rq.sample_time);
         rs.acceleration = dr[31:0];
         rs.saturated |= dr[32];
         dr = sample_derivative(3, rq.sample_time);
         rs.jerk_value = dr[31:0];
         rs.saturated |= dr[32];
      end else if (rq.action == ACT_CUBIC || rq.action == ACT_QUINTIC) begin
         if (rq.interval == 0) begin
            rs.status = ST_BAD_INTERVAL;
            return rs;
         end
         c[0] = p1 <<< 16;
         c[1] = v1 <<< 16;
         if (rq.action == ACT_CUBIC) begin
            cr = solve_coef(0, -(2 * v1 + v2), 3 * (p2 - p1), rq.interval, 2, 1);
            c[2] = cr[63:0];
            rs.saturated |= cr[64];
            cr = solve_coef(0, v1 + v2, 2 * (p1 - p2), rq.interval, 3, 1);
            c[3] = cr[63:0];
            rs.saturated |= cr[64];
            c[4] = 0;
            c[5] = 0;
         end else begin
            c[2] = a1 <<< 15;
            cr = solve_coef(a2 - 3 * a1, -(8 * v2 + 12 * v1), 20 * (p2 - p1),
                            rq.interval, 3, 2);
            c[3] = cr[63:0];
            rs.saturated |= cr[64];
            cr = solve_coef(3 * a1 - 2 * a2, 14 * v2 + 16 * v1, 30 * (p1 - p2),
                            rq.interval, 4, 2);
            c[4] = cr[63:0];
            rs.saturated |= cr[64];
            cr = solve_coef(a2 - a1, -6 * (v1 + v2), 12 * (p2 - p1), rq.interval, 5, 2);
            c[5] = cr[63:0];
            rs.saturated |= cr[64];
         end
         for (int i = 0; i < 6; i++) segment_coef[i] = c[i];
      end
      return rs;
   endfunction

   // Request driver: predict on each transfer, then present the next request
   always @(posedge clock) begin
      segment_req_type nx;
      logic nv;
      nv = req_tvalid;
      if (reset) begin
         nv = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_motion.push_back(run_segment(in_flight));
            nv = 1'b0;
         end
         if (!nv && pending_reqs.size() > 0 &&
             $urandom_range(0, 99) >= sender_idle_pct) begin
            nx = pending_reqs.pop_front();
            in_flight = nx;
            req_tdata <= {nx.end_acc, nx.end_vel, nx.end_pos, nx.start_acc,
                          nx.start_vel, nx.start_pos, nx.interval, nx.sample_time};
            req_tuser <= nx.action;
            nv = 1'b1;
         end
      end
      req_tvalid <= nv;
   end

   // Response monitor: check each transfer against the oldest expectation
   always @(posedge clock) begin
      motion_rsp_type exp_rsp;
      logic [31:0] got[4];
      logic [31:0] want[4];
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tdata[127:96]};
         if (expected_motion.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response tdata=%h tuser=%b", rsp_tdata, rsp_tuser);
         end else begin
            exp_rsp = expected_motion.pop_front();
            want = '{exp_rsp.position, exp_rsp.velocity, exp_rsp.acceleration,
                     exp_rsp.jerk_value};
            if (got != want || rsp_tuser[0] !== exp_rsp.status ||
                rsp_tuser[1] !== exp_rsp.saturated) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: pos %h/%h vel %h/%h acc %h/%h jerk %h/%h st %b/%b sat %b/%b",
                           want[0], got[0], want[1], got[1], want[2], got[2],
                           want[3], got[3], exp_rsp.status, rsp_tuser[0],
                           exp_rsp.saturated, rsp_tuser[1]);
            end
         end
      end
      // Hold off for a long stretch on request, else stall at random
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = 3000;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   function automatic logic [31:0] pick_field();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $signed($urandom) >>> $urandom_range(8, 31);
         2: begin
            case ($urandom_range(0, 4))
               0: return 32'h80000000;
               1: return 32'h7FFFFFFF;
               2: return 32'h0;
               3: return 32'h1;
               default: return 32'hFFFFFFFF;
            endcase
         end
         default: return $signed($urandom) >>> $urandom_range(10, 20);
      endcase
   endfunction

   function automatic logic [31:0] pick_interval();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return $urandom_range(1, 255);
         default: return $urandom_range(32'h1000, 32'h80000);
      endcase
   endfunction

   task automatic queue_req(logic [1:0] act, logic [31:0] st, logic [31:0] iv,
                            logic [31:0] sp, logic [31:0] sv, logic [31:0] sa,
                            logic [31:0] ep, logic [31:0] ev, logic [31:0] ea);
      segment_req_type rq;
      rq = '{act, st, iv, sp, sv, sa, ep, ev, ea};
      pending_reqs.push_back(rq);
   endtask

   // Fit a segment with random content, then queue one to five requests that mostly sample it
   task automatic queue_segment(output int count);
      logic [31:0] iv;
      logic [1:0]  act;
      int n;
      act = $urandom_range(0, 1) ? ACT_QUINTIC : ACT_CUBIC;
      iv = ($urandom_range(0, 19) == 0) ? 32'd0 : pick_interval();
      queue_req(act, $urandom, iv, pick_field(), pick_field(), pick_field(),
                pick_field(), pick_field(), pick_field());
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0: queue_req(ACT_EVAL, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom);
            1: queue_req(ACT_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom);
            default: queue_req(ACT_EVAL, (iv == 0) ? $urandom : $urandom_range(0, iv),
                               $urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom);
         endcase
      end
      count = n + 1;
   endtask

   // Sample at the falling edge so the driver's updates have settled
   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_tvalid || expected_motion.size() > 0)
         @(negedge clock);
   endtask

   // Stimulus and final verdict
   initial begin
      int sent;
      int cnt;
      int idle_modes[4][2];
      idle_modes = '{'{0, 0}, '{48, 0}, '{0, 48}, '{17, 17}};
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = ACT_EVAL;
      rsp_tready = 1'b0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      mismatch_count = 0;
      hold_left = 0;
      hold_request = 1'b0;
      for (int i = 0; i < 6; i++) segment_coef[i] = '0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset state, zero interval, extremes, unused action
      queue_req(ACT_EVAL, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 0);
      queue_req(ACT_CUBIC, 0, 0, 32'h7FFFFFFF, 1, 1, 1, 1, 1);
      queue_req(ACT_QUINTIC, 0, 0, 32'h80000000, 1, 1, 1, 1, 1);
      queue_req(ACT_EVAL, 0, 0, 0, 0, 0, 0, 0, 0);
      queue_req(ACT_CUBIC, 0, 32'h00010000, 32'h00010000, 0, 0, 32'h00050000,
                32'h00010000, 0);
      queue_req(ACT_EVAL, 32'h00008000, 0, 0, 0, 0, 0, 0, 0);
      queue_req(ACT_EVAL, 32'h00010000, 0, 0, 0, 0, 0, 0, 0);
      queue_req(ACT_QUINTIC, 0, 32'h00020000, 32'hFFFF0000, 32'h00008000,
                32'hFFFE0000, 32'h00030000, 0, 32'h00010000);
      queue_req(ACT_EVAL, 32'h00018000, 0, 0, 0, 0, 0, 0, 0);
      queue_req(ACT_QUINTIC, 0, 32'd1, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      queue_req(ACT_EVAL, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 0);
      queue_req(ACT_EVAL, 32'd1, 0, 0, 0, 0, 0, 0, 0);
      queue_req(ACT_CUBIC, 0, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
      queue_req(ACT_EVAL, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 0);
      queue_req(ACT_EVAL, 32'h80000000, 0, 0, 0, 0, 0, 0, 0);
      queue_req(ACT_QUINTIC, 0, 32'hFFFFFFFF, 32'h80000000, 32'h80000000,
                32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      queue_req(ACT_EVAL, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 0);
      queue_req(ACT_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      queue_req(ACT_EVAL, 32'h00004000, 0, 0, 0, 0, 0, 0, 0);
      wait_drained();

      // Random segments across the idling phases
      for (int ph = 0; ph < 4; ph++) begin
         sender_idle_pct = idle_modes[ph][0];
         receiver_stall_pct = idle_modes[ph][1];
         if (ph == 0) hold_request = 1'b1;
         sent = 0;
         while (sent < 345) begin
            queue_segment(cnt);
            sent += cnt;
            while (pending_reqs.size() > 4) @(posedge clock);
         end
         // Pause the sender until every response is back
         wait_drained();
      end

      repeat (1000) @(posedge clock);
      if (expected_motion.size() > 0) mismatch_count++;
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Run limit
   initial begin
      #200000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
